### rtl/pqe_pkg.sv
// Shared constants, sideband type and an elaboration-time helper for the PQ encoder.
package pqe_pkg;

    localparam int unsigned Q             = 30;
    localparam int unsigned FRAC_BITS_DEF = 4;
    localparam int unsigned LUM_W         = 20;
    localparam int unsigned CODE_W        = 12;
    localparam int unsigned REF_NITS      = 10000;

    localparam logic [CODE_W-1:0] CODE_MAX  = 12'd4095;
    localparam logic [CODE_W-1:0] CODE_ZERO = 12'd0;

    // ln(2) in Q30.
    localparam logic [Q-1:0] LN2_Q = 30'd744261118;

    // PQ constants as exact integer ratios.
    localparam int unsigned C1_NUM   = 3424;  // c1 = 3424 / 2^12
    localparam int unsigned C1_SH    = 12;
    localparam int unsigned C2_NUM   = 2413;  // c2 = 2413 / 2^7
    localparam int unsigned C3_NUM   = 2392;  // c3 = 2392 / 2^7
    localparam int unsigned C23_SH   = 7;
    localparam int unsigned M1_NUM   = 1305;  // m1 = 1305 / 2^13
    localparam int unsigned M1_SH    = 13;
    localparam int unsigned M2_NUM   = 2523;  // m2 = 2523 / 2^5
    localparam int unsigned M2_SH    = 5;
    localparam int unsigned CODE_SCALE = 4095;

    // The ratio r is held with this many fraction bits.
    localparam int unsigned RATIO_FRAC = 28;
    localparam int unsigned RATIO_W    = RATIO_FRAC + 1;

    // Log results carry five integer bits above the Q30 fraction.
    localparam int unsigned LOG_INT_W = 5;
    localparam int unsigned LOG_W     = LOG_INT_W + Q;

    // Numerator and denominator of the ratio.
    localparam int unsigned ND_W = 35;

    // Sideband that travels with every sample: a forced code for the special cases.
    typedef struct packed {
        logic              force_en;
        logic [CODE_W-1:0] code;
    } side_t;

    // Q30 log2 of a constant, evaluated at elaboration time only.
    function automatic logic [63:0] log2q_const(input logic [63:0] v);
        logic [63:0] z;
        logic [63:0] frac;
        int unsigned p;
        p = 0;
        for (int unsigned i = 1; i < 64; i++) begin
            if ((v >> i) != 64'd0) begin
                p = i;
            end
        end
        if (p <= Q) begin
            z = v << (Q - p);
        end else begin
            z = v >> (p - Q);
        end
        frac = '0;
        for (int b = Q - 1; b >= 0; b--) begin
            z = (z * z) >> Q;
            if (z >= (64'd1 << (Q + 1))) begin
                z = z >> 1;
                frac[b] = 1'b1;
            end
        end
        return (64'(p) << Q) + frac;
    endfunction

endpackage

### rtl/pq_oetf_encoder_12bit_core.sv
// PQ encoder core: linear luminance in, 12-bit ST 2084 code out.
// It accepts one sample per cycle except while the pipeline holds.
// The depth is mostly set by the two 31-stage log2 pipelines, the two 42-stage exp2
// series pipelines and the 29-stage divider. The whole pipeline holds while a
// result waits at the output. aresetn is synchronous and active low; it clears
// every valid bit, while data registers keep their contents.
module pq_oetf_encoder_12bit_core #(
    parameter int unsigned FRAC_BITS = pqe_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [pqe_pkg::LUM_W-1:0]  s_luminance,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pqe_pkg::CODE_W-1:0]        m_pq_code
);
    import pqe_pkg::*;

    // 10000 cd/m2 in input units, and its log2 as a constant.
    localparam logic [31:0]      REF  = 32'(REF_NITS) << FRAC_BITS;
    localparam logic [LOG_W-1:0] LREF = LOG_W'(log2q_const(64'(REF)));
    localparam logic [LOG_W-1:0] L28  = LOG_W'(RATIO_FRAC) << Q;

    localparam int unsigned XW    = LUM_W - 1;
    localparam int unsigned NMP_W = LOG_W + 11;
    localparam int unsigned NVP_W = LOG_W + 12;
    localparam int unsigned YP_W  = Q + 1 + 12;
    localparam int unsigned CP_W  = Q + 1 + 12;

    // Output register.
    logic              m_valid_reg;
    logic [CODE_W-1:0] m_pq_code_reg;

    // A single advance enable: every stage moves when the output register can take data.
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Input register.
    logic             in_valid_reg;
    logic [LUM_W-1:0] lum_reg;

    // Special cases are decided up front and ride along as a forced code.
    logic  is_neg;
    logic  is_zero;
    logic  is_sat;
    side_t side0;

    always_comb begin
        is_neg  = lum_reg[LUM_W-1];
        is_zero = lum_reg == '0;
        is_sat  = 32'(lum_reg) >= REF;
        side0.force_en = is_neg || is_zero || is_sat;
        side0.code     = (is_neg || is_zero) ? CODE_ZERO : CODE_MAX;
    end

    // Y^m1 path: log2 of the sample, distance below the reference, scaled by m1.
    logic             lx_valid;
    logic [LOG_W-1:0] lx;
    side_t            lx_side;

    pqe_log2 #(.IN_W(XW)) u_log_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_x      (lum_reg[XW-1:0]),
        .in_side   (side0),
        .out_valid (lx_valid),
        .out_log   (lx),
        .out_side  (lx_side)
    );

    logic             ny_valid_reg;
    logic [LOG_W-1:0] ny_reg;
    side_t            ny_side_reg;
    logic             nmp_valid_reg;
    logic [NMP_W-1:0] nmp_reg;
    side_t            nmp_side_reg;

    logic       ym_valid;
    logic [Q:0] ym;
    side_t      ym_side;

    pqe_exp2 #(.T_W(NMP_W - M1_SH)) u_exp_m1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (nmp_valid_reg),
        .in_t      (nmp_reg[NMP_W-1:M1_SH]),
        .in_side   (nmp_side_reg),
        .out_valid (ym_valid),
        .out_v     (ym),
        .out_side  (ym_side)
    );

    // Numerator and denominator of the rational part; the two multiplies run side by side.
    logic            nd_valid_reg;
    logic [ND_W-1:0] num_reg;
    logic [ND_W-1:0] den_reg;
    side_t           nd_side_reg;
    logic [YP_W-1:0] c2_prod;
    logic [YP_W-1:0] c3_prod;

    assign c2_prod = YP_W'(ym) * YP_W'(C2_NUM);
    assign c3_prod = YP_W'(ym) * YP_W'(C3_NUM);

    logic               rt_valid;
    logic [RATIO_W-1:0] ratio;
    side_t              rt_side;
    side_t              rt_side_fix;

    pqe_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (nd_valid_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_side   (nd_side_reg),
        .out_valid (rt_valid),
        .out_q     (ratio),
        .out_side  (rt_side)
    );

    // A ratio that truncates to zero encodes to zero.
    always_comb begin
        rt_side_fix = rt_side;
        if (!rt_side.force_en && ratio == '0) begin
            rt_side_fix.force_en = 1'b1;
            rt_side_fix.code     = CODE_ZERO;
        end
    end

    // r^m2 path: log2 of the Q28 ratio, distance below one, scaled by m2.
    logic             lr_valid;
    logic [LOG_W-1:0] lr;
    side_t            lr_side;

    pqe_log2 #(.IN_W(RATIO_W)) u_log_r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rt_valid),
        .in_x      (ratio),
        .in_side   (rt_side_fix),
        .out_valid (lr_valid),
        .out_log   (lr),
        .out_side  (lr_side)
    );

    logic             n2_valid_reg;
    logic [LOG_W-1:0] n2_reg;
    side_t            n2_side_reg;
    logic             nvp_valid_reg;
    logic [NVP_W-1:0] nvp_reg;
    side_t            nvp_side_reg;

    logic       v_valid;
    logic [Q:0] v;
    side_t      v_side;

    pqe_exp2 #(.T_W(NVP_W - M2_SH)) u_exp_m2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (nvp_valid_reg),
        .in_t      (nvp_reg[NVP_W-1:M2_SH]),
        .in_side   (nvp_side_reg),
        .out_valid (v_valid),
        .out_v     (v),
        .out_side  (v_side)
    );

    // Scale to 4095 with round half up, then saturate or apply the forced code.
    logic            cp_valid_reg;
    logic [CP_W-1:0] cp_reg;
    side_t           cp_side_reg;
    logic [CODE_W:0] code_full;
    logic [CODE_W-1:0] code_next;

    always_comb begin
        code_full = cp_reg[CP_W-1:Q];
        if (cp_side_reg.force_en) begin
            code_next = cp_side_reg.code;
        end else if (code_full > {1'b0, CODE_MAX}) begin
            code_next = CODE_MAX;
        end else begin
            code_next = code_full[CODE_W-1:0];
        end
    end

    // Valid bits of the stages kept at this level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            ny_valid_reg  <= 1'b0;
            nmp_valid_reg <= 1'b0;
            nd_valid_reg  <= 1'b0;
            n2_valid_reg  <= 1'b0;
            nvp_valid_reg <= 1'b0;
            cp_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (en) begin
            in_valid_reg  <= s_valid;
            ny_valid_reg  <= lx_valid;
            nmp_valid_reg <= ny_valid_reg;
            nd_valid_reg  <= ym_valid;
            n2_valid_reg  <= lr_valid;
            nvp_valid_reg <= n2_valid_reg;
            cp_valid_reg  <= v_valid;
            m_valid_reg   <= cp_valid_reg;
        end
    end

    // Data registers of those stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            lum_reg      <= s_luminance;
            ny_reg       <= (LREF > lx) ? (LREF - lx) : '0;
            ny_side_reg  <= lx_side;
            nmp_reg      <= NMP_W'(ny_reg) * NMP_W'(M1_NUM);
            nmp_side_reg <= ny_side_reg;
            num_reg      <= (ND_W'(C1_NUM) << (Q - C1_SH)) + ND_W'(c2_prod >> C23_SH);
            den_reg      <= (ND_W'(1) << Q) + ND_W'(c3_prod >> C23_SH);
            nd_side_reg  <= ym_side;
            n2_reg       <= (L28 > lr) ? (L28 - lr) : '0;
            n2_side_reg  <= lr_side;
            nvp_reg      <= NVP_W'(n2_reg) * NVP_W'(M2_NUM);
            nvp_side_reg <= n2_side_reg;
            cp_reg       <= CP_W'(v) * CP_W'(CODE_SCALE) + (CP_W'(1) << (Q - 1));
            cp_side_reg  <= v_side;
            m_pq_code_reg <= code_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pq_code = m_pq_code_reg;

endmodule

### rtl/pqe_log2.sv
// Pipelined Q30 log2: normalize, then one squaring step per stage for each fraction bit.
module pqe_log2 #(
    parameter int unsigned IN_W = 19
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [IN_W-1:0]          in_x,
    input  pqe_pkg::side_t           in_side,
    output logic                     out_valid,
    output logic [pqe_pkg::LOG_W-1:0] out_log,
    output pqe_pkg::side_t           out_side
);
    import pqe_pkg::*;

    localparam int unsigned ZW = Q + 1;
    localparam int unsigned NS = Q + 1;

    logic [NS-1:0]        valid_reg;
    logic [ZW-1:0]        z_reg    [NS];
    logic [Q-1:0]         frac_reg [NS];
    logic [LOG_INT_W-1:0] p_reg    [NS];
    side_t                side_reg [NS];

    logic [ZW-1:0]        z_next    [NS];
    logic [Q-1:0]         frac_next [NS];
    logic [LOG_INT_W-1:0] p_next    [NS];
    side_t                side_next [NS];

    logic [2*ZW-1:0]      sq [1:NS-1];
    logic [ZW:0]          t  [1:NS-1];
    logic [ZW-1:0]        x_ext;
    logic [LOG_INT_W-1:0] msb;

    always_comb begin
        msb = '0;
        for (int i = 1; i < IN_W; i++) begin
            if (in_x[i]) begin
                msb = LOG_INT_W'(i);
            end
        end
        x_ext = ZW'(in_x);
        z_next[0]    = x_ext << (6'(Q) - 6'(msb));
        frac_next[0] = '0;
        p_next[0]    = msb;
        side_next[0] = in_side;
        for (int s = 1; s < NS; s++) begin
            sq[s] = (2*ZW)'(z_reg[s-1]) * (2*ZW)'(z_reg[s-1]);
            t[s]  = sq[s][Q +: ZW+1];
            // A square at or above two contributes a one bit and is halved.
            z_next[s]    = t[s][ZW] ? t[s][ZW:1] : t[s][ZW-1:0];
            frac_next[s] = frac_reg[s-1] | (Q'(t[s][ZW]) << (Q - s));
            p_next[s]    = p_reg[s-1];
            side_next[s] = side_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NS; s++) begin
                z_reg[s]    <= z_next[s];
                frac_reg[s] <= frac_next[s];
                p_reg[s]    <= p_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_log   = {p_reg[NS-1], frac_reg[NS-1]};
    assign out_side  = side_reg[NS-1];

endmodule

### rtl/pqe_exp2.sv
// Pipelined Q30 2^-t: a 20-term series of e^-u, one multiply stage and one
// reciprocal stage per term, then the integer shift.
module pqe_exp2 #(
    parameter int unsigned T_W = 33
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [T_W-1:0] in_t,
    input  pqe_pkg::side_t in_side,
    output logic           out_valid,
    output logic [pqe_pkg::Q:0] out_v,
    output pqe_pkg::side_t out_side
);
    import pqe_pkg::*;

    localparam int unsigned NTERM = 20;
    localparam int unsigned NS    = 2 * NTERM + 2;
    localparam int unsigned IW    = T_W - Q;
    localparam int unsigned TW    = Q + 1;

    logic [NS-1:0] valid_reg;
    logic [Q-1:0]  u_reg    [NS];
    logic [5:0]    ish_reg  [NS];
    logic          zero_reg [NS];
    logic [31:0]   pos_reg  [NS];
    logic [31:0]   neg_reg  [NS];
    logic [TW-1:0] term_reg [NS];
    side_t         side_reg [NS];

    logic [Q-1:0]  u_next    [NS];
    logic [5:0]    ish_next  [NS];
    logic          zero_next [NS];
    logic [31:0]   pos_next  [NS];
    logic [31:0]   neg_next  [NS];
    logic [TW-1:0] term_next [NS];
    side_t         side_next [NS];

    // Reciprocal constants for the exact divide of each term by its index.
    logic [31:0] recip_m  [1:NTERM];
    logic [5:0]  recip_sh [1:NTERM];

    for (genvar k = 1; k <= NTERM; k++) begin : g_recip
        localparam int unsigned L  = $clog2(k);
        localparam logic [63:0] M  = ((64'd1 << (Q + L)) + 64'(k) - 64'd1) / 64'(k);
        assign recip_m[k]  = 32'(M);
        assign recip_sh[k] = 6'(Q + L);
    end

    logic [IW-1:0]  i_full;
    logic [2*Q-1:0] u_prod;
    logic [60:0]    mul_prod [1:NTERM];
    logic [61:0]    div_prod [1:NTERM];
    logic [31:0]    r_diff;

    always_comb begin
        i_full       = in_t[T_W-1:Q];
        u_prod       = (2*Q)'(in_t[Q-1:0]) * (2*Q)'(LN2_Q);
        u_next[0]    = u_prod[2*Q-1:Q];
        ish_next[0]  = 6'(i_full);
        zero_next[0] = 32'(i_full) >= 32'd62;
        pos_next[0]  = 32'd1 << Q;
        neg_next[0]  = '0;
        term_next[0] = TW'(1) << Q;
        side_next[0] = in_side;
        for (int s = 1; s < NS; s++) begin
            u_next[s]    = u_reg[s-1];
            ish_next[s]  = ish_reg[s-1];
            zero_next[s] = zero_reg[s-1];
            pos_next[s]  = pos_reg[s-1];
            neg_next[s]  = neg_reg[s-1];
            term_next[s] = term_reg[s-1];
            side_next[s] = side_reg[s-1];
        end
        for (int k = 1; k <= NTERM; k++) begin
            // Multiply stage: term * u, back to Q30.
            mul_prod[k]      = 61'(term_reg[2*k-2]) * 61'(u_reg[2*k-2]);
            term_next[2*k-1] = TW'(mul_prod[k] >> Q);
            // Divide stage: multiply by the rounded-up reciprocal, exact for 30-bit terms.
            div_prod[k]      = 62'(term_reg[2*k-1]) * 62'(recip_m[k]);
            term_next[2*k]   = TW'(div_prod[k] >> recip_sh[k]);
            if (k % 2 == 1) begin
                neg_next[2*k] = neg_reg[2*k-1] + 32'(term_next[2*k]);
            end else begin
                pos_next[2*k] = pos_reg[2*k-1] + 32'(term_next[2*k]);
            end
        end
        r_diff = (pos_reg[NS-2] > neg_reg[NS-2]) ? (pos_reg[NS-2] - neg_reg[NS-2]) : 32'd0;
        term_next[NS-1] = zero_reg[NS-2] ? '0 : TW'(r_diff >> ish_reg[NS-2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NS; s++) begin
                u_reg[s]    <= u_next[s];
                ish_reg[s]  <= ish_next[s];
                zero_reg[s] <= zero_next[s];
                pos_reg[s]  <= pos_next[s];
                neg_reg[s]  <= neg_next[s];
                term_reg[s] <= term_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_v     = term_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

### rtl/pqe_div.sv
// Pipelined restoring divider: (num << 28) / den, one quotient bit per stage.
module pqe_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [pqe_pkg::ND_W-1:0]    in_num,
    input  logic [pqe_pkg::ND_W-1:0]    in_den,
    input  pqe_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [pqe_pkg::RATIO_W-1:0] out_q,
    output pqe_pkg::side_t              out_side
);
    import pqe_pkg::*;

    localparam int unsigned NS = RATIO_W;

    logic [NS-1:0]      valid_reg;
    logic [ND_W-1:0]    r_reg    [NS];
    logic [ND_W-1:0]    den_reg  [NS];
    logic [RATIO_W-1:0] q_reg    [NS];
    side_t              side_reg [NS];

    logic [ND_W-1:0]    r_next    [NS];
    logic [ND_W-1:0]    den_next  [NS];
    logic [RATIO_W-1:0] q_next    [NS];
    side_t              side_next [NS];

    logic [ND_W:0] r2 [1:NS-1];
    logic          ge [NS];

    always_comb begin
        // The numerator never exceeds the denominator, so the top bit is a plain compare.
        ge[0]        = in_num >= in_den;
        r_next[0]    = ge[0] ? (in_num - in_den) : in_num;
        den_next[0]  = in_den;
        q_next[0]    = RATIO_W'(ge[0]) << (RATIO_W - 1);
        side_next[0] = in_side;
        for (int s = 1; s < NS; s++) begin
            r2[s]        = {r_reg[s-1], 1'b0};
            ge[s]        = r2[s] >= {1'b0, den_reg[s-1]};
            r_next[s]    = ge[s] ? ND_W'(r2[s] - {1'b0, den_reg[s-1]}) : ND_W'(r2[s]);
            den_next[s]  = den_reg[s-1];
            q_next[s]    = q_reg[s-1] | (RATIO_W'(ge[s]) << (RATIO_W - 1 - s));
            side_next[s] = side_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NS; s++) begin
                r_reg[s]    <= r_next[s];
                den_reg[s]  <= den_next[s];
                q_reg[s]    <= q_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_q     = q_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

### tb/pq_oetf_encoder_12bit_core_checker.sv
// Channel monitor, PQ code predictor and result comparator for the PQ encoder core.
module pq_oetf_encoder_12bit_core_checker #(
    parameter int unsigned FRAC_BITS = pqe_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic signed [pqe_pkg::LUM_W-1:0] s_luminance,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [pqe_pkg::CODE_W-1:0]       m_pq_code,
    output int                               failures,
    output int                               codes_pending,
    output int                               codes_seen
);
    import pqe_pkg::*;

    localparam logic [63:0] ONE_Q = 64'd1 << Q;

    logic [CODE_W-1:0] expected_codes[$];

    function automatic logic [63:0] fix_log2(input logic [63:0] v);
        logic [63:0] z;
        logic [63:0] frac;
        int unsigned p;
        p = 0;
        frac = '0;
        if (v == 0) return 0;
        for (int unsigned i = 1; i < 64; i++)
            if ((v >> i) != 0) p = i;
        z = (p <= Q) ? (v << (Q - p)) : (v >> (p - Q));
        for (int b = Q - 1; b >= 0; b--) begin
            z = (z * z) >> Q;
            if (z >= (ONE_Q << 1)) begin
                z = z >> 1;
                frac[b] = 1'b1;
            end
        end
        return (64'(p) << Q) + frac;
    endfunction

    // 2^-t via a truncated series of e^-u on the fractional part.
    function automatic logic [63:0] fix_exp2_neg(input logic [63:0] t);
        logic [63:0] ipart, u, term, pos, neg;
        ipart = t >> Q;
        u = ((t & (ONE_Q - 1)) * 64'(LN2_Q)) >> Q;
        term = ONE_Q;
        pos = ONE_Q;
        neg = 0;
        if (ipart >= 62) return 0;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * u) >> Q) / 64'(k);
            if (k % 2 == 1) neg += term;
            else pos += term;
        end
        return ((pos > neg) ? (pos - neg) : 64'd0) >> ipart;
    endfunction

    function automatic logic [CODE_W-1:0] luminance_to_pq(input logic [LUM_W-1:0] raw);
        logic [63:0] ref_lum, lx, lref, ny, ym, num, den, ratio, lr, n2, v, code;
        ref_lum = 64'(REF_NITS) << FRAC_BITS;
        if (raw[LUM_W-1] || raw == 0) return CODE_ZERO;
        if (64'(raw) >= ref_lum) return CODE_MAX;
        lx = fix_log2(64'(raw));
        lref = fix_log2(ref_lum);
        ny = (lref > lx) ? (lref - lx) : 64'd0;
        ym = fix_exp2_neg((ny * M1_NUM) >> M1_SH);
        num = (64'(C1_NUM) << (Q - C1_SH)) + ((ym * C2_NUM) >> C23_SH);
        den = ONE_Q + ((ym * C3_NUM) >> C23_SH);
        ratio = (num << RATIO_FRAC) / den;
        if (ratio == 0) return CODE_ZERO;
        lr = fix_log2(ratio);
        n2 = ((64'(RATIO_FRAC) << Q) > lr) ? ((64'(RATIO_FRAC) << Q) - lr) : 64'd0;
        v = fix_exp2_neg((n2 * M2_NUM) >> M2_SH);
        code = (v * CODE_SCALE + (ONE_Q >> 1)) >> Q;
        if (code > CODE_SCALE) code = CODE_SCALE;
        return code[CODE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        failures++;
    endtask

    always @(posedge aclk) begin
        logic [CODE_W-1:0] want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_codes.push_back(luminance_to_pq(s_luminance));
            if (m_valid && m_ready) begin
                codes_seen++;
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("unexpected pq_code %0d", m_pq_code));
                end else begin
                    want = expected_codes.pop_front();
                    if (m_pq_code !== want)
                        report_mismatch($sformatf("pq_code %0d, expected %0d",
                                                  m_pq_code, want));
                end
            end
            codes_pending = expected_codes.size();
        end
    end

    final begin
        if (expected_codes.size() != 0)
            $display("MISMATCH: %0d codes never arrived", expected_codes.size());
    end
endmodule

### tb/pq_oetf_encoder_12bit_core_test.sv
// Top-level testbench for the PQ encoder core: stimulus, flow control and verdict.
module pq_oetf_encoder_12bit_core_test;
    import pqe_pkg::*;

    // Full scale of the encoder: 10000 cd/m2 in input units.
    localparam int REF_LUM = REF_NITS << FRAC_BITS_DEF;
    // Longer than the pipeline depth; the end of the run waits at least this long.
    localparam int DRAIN_CYCLES = 400;
    // Cycles without any transfer that count as a hang.
    localparam int HANG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1300;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [LUM_W-1:0] s_luminance = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [CODE_W-1:0]       m_pq_code;

    int failures, codes_pending, codes_seen;
    int items_sent = 0;
    int idle_cycles = 0;
    logic s_fire = 1'b0;

    always #5 aclk = ~aclk;

    pq_oetf_encoder_12bit_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_luminance(s_luminance),
        .m_valid(m_valid), .m_ready(m_ready), .m_pq_code(m_pq_code)
    );

    pq_oetf_encoder_12bit_core_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_luminance(s_luminance),
        .m_valid(m_valid), .m_ready(m_ready), .m_pq_code(m_pq_code),
        .failures(failures), .codes_pending(codes_pending), .codes_seen(codes_seen)
    );

    // Register the input handshake at the rising edge so that the sender can look
    // at it on the following falling edge without any race against the core.
    always @(posedge aclk) s_fire <= aresetn && s_valid && s_ready;

    // The watchdog counts cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
            $display("pq_oetf_encoder_12bit_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver switches at random between phases: always ready, coin-flip stalls and
    // mostly-stalled back-pressure, so that the whole pipeline is held at many different fills.
    int stall_phase = 0;
    int phase_left = 0;
    always @(negedge aclk) begin
        if (phase_left == 0) begin
            stall_phase <= $urandom_range(0, 2);
            phase_left <= $urandom_range(20, 300);
        end else begin
            phase_left <= phase_left - 1;
        end
        case (stall_phase)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Present one sample and hold it until the core takes it. Valid stays high
    // afterwards, so back-to-back calls produce a burst without a bubble.
    task automatic send_luminance(input logic signed [LUM_W-1:0] lum);
        s_valid = 1'b1;
        s_luminance = lum;
        do @(negedge aclk); while (!s_fire);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        s_valid = 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Random luminance shaped to cover the whole curve: mostly positive values
    // spread over every octave below full scale, plus small levels, the saturation threshold
    // and its neighbors, the saturated and negative regions and raw random words.
    function automatic logic signed [LUM_W-1:0] pick_luminance();
        int sel, octave;
        sel = $urandom_range(0, 9);
        octave = $urandom_range(0, 17);
        case (sel)
            0: return LUM_W'($urandom());
            1: return LUM_W'(-$signed($urandom_range(1, 524288)));
            2: return LUM_W'($urandom_range(REF_LUM, 524287));
            3: return LUM_W'($urandom_range(REF_LUM - 8, REF_LUM + 8));
            4: return LUM_W'($urandom_range(1, 64));
            default: return LUM_W'($urandom_range(1 << octave, (2 << octave) - 1)
                                   % REF_LUM + 1);
        endcase
    endfunction

    initial begin
        logic signed [LUM_W-1:0] directed[$];
        int burst;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Field extremes, the zero and negative cases, small and mid-range levels, the saturation
        // threshold and its neighbors, and alternating bit patterns.
        directed = '{-20'sd524288, -20'sd1, 20'sd0, 20'sd1, 20'sd2, 20'sd3,
                     20'sd16, 20'sd1600, 20'sd16000, 20'sd80000,
                     20'(REF_LUM - 2), 20'(REF_LUM - 1), 20'(REF_LUM), 20'(REF_LUM + 1),
                     20'sd524287, 20'sh55555, 20'shAAAAA, 20'sh2AAAA, 20'sh15555,
                     20'sh7FFFF, 20'sh00100};
        foreach (directed[i]) send_luminance(directed[i]);
        pause_sender(3);

        for (int n = 0; n < RANDOM_ITEMS; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++)
                send_luminance(pick_luminance());
            if (n > RANDOM_ITEMS / 2 && n - burst <= RANDOM_ITEMS / 2) begin
                // Let the pipeline drain completely before carrying on.
                s_valid = 1'b0;
                while (codes_pending != 0) @(negedge aclk);
            end
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 15));
        end
        s_valid = 1'b0;

        while (codes_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d luminance samples (directed edges, every octave, negatives,",
                 items_sent);
        $display("saturation) and checked %0d PQ codes under random back-pressure.",
                 codes_seen);
        if (failures == 0 && codes_pending == 0) begin
            $display("pq_oetf_encoder_12bit_core verification clean");
        end else begin
            $display("pq_oetf_encoder_12bit_core verification failed");
        end
        $finish;
    end
endmodule
